### rtl/lbh_pkg.sv
// Shared constants and types for the lookup2 byte hash.
// Used by the front end, job queue, back-end mixer and top level.
`default_nettype none

package lbh_pkg;

	localparam int LENGTH_BITS = 16;
	localparam logic [31:0] GOLDEN_WORD = 32'h9e3779b9;
	localparam logic [31:0] INIT_RESET = 32'hfeedbeef;
	localparam logic [3:0] GROUP_LAST = 4'd11;   // position of the twelfth byte of a group

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

	// One unit of work for the mixer: a group (full or tail) of key bytes.
	typedef struct packed {
		logic [31:0]            wa;
		logic [31:0]            wb;
		logic [31:0]            wc;
		logic                   full;    // twelve bytes at natural weight
		logic                   closing; // closes the key
		logic                   first;   // opens the key, start from the seed words
		logic [LENGTH_BITS-1:0] count;
		logic                   ovf;
	} job_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MIX,
		ST_ADDLEN,
		ST_EMIT
	} back_state_t;

endpackage

`default_nettype wire

### rtl/lbh_if.sv
// Valid/ready channel interfaces for the key byte stream and the hash result.
// Standalone; no package dependency.
`default_nettype none

interface lbh_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, output data_byte, output last_byte, input ready);
	modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface lbh_hash_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest;
	logic        too_long;

	modport source(output valid, output digest, output too_long, input ready);
	modport sink(input valid, input digest, input too_long, output ready);
endinterface

`default_nettype wire

### rtl/lookup2_byte_hash.sv
// Lookup2 hash of a byte-serial key: one byte per transaction on key, one
// result transaction on hash per key. A byte is taken every cycle while the
// four-entry job queue has room. Each group of twelve bytes becomes one job for
// the mixer, which adds it into the hash words and then runs the nine mix rows,
// one row per cycle, so the body of a long key streams at one byte per cycle.
// The closing job also loads the result register; when the key length is a
// multiple of twelve it runs the group mix, then adds the length and mixes
// again. The mixer's time per key bounds the rate of short keys.
// init_value is sampled at the first job of each key.
// Depends on lbh_pkg, lbh_if, lbh_front, lbh_fifo, lbh_back.
`default_nettype none

module lookup2_byte_hash (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	lbh_byte_if.sink         key,
	lbh_hash_if.source       hash
);
	import lbh_pkg::*;

	logic [31:0] init_q;
	logic        q_push, q_ready, q_pop, q_valid;
	job_t        wr_job, rd_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= INIT_RESET;
		end else if (cfg_we) begin
			init_q <= cfg_wdata;
		end
	end

	lbh_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.key     (key),
		.push    (q_push),
		.q_ready (q_ready),
		.job     (wr_job)
	);

	lbh_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_job (wr_job),
		.ready  (q_ready),
		.pop    (q_pop),
		.rd_job (rd_job),
		.valid  (q_valid)
	);

	lbh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_job      (rd_job),
		.pop        (q_pop),
		.init_value (init_q),
		.hash       (hash)
	);

	// every closing byte must produce a queued job marked as closing
	a_last_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(key.valid && key.ready && key.last_byte) |-> (q_push && wr_job.closing))
		else $error("closing byte did not queue a closing job");

	// queue is never written while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> q_ready)
		else $error("job pushed into full queue");

	// mixer only takes jobs that are present
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("job popped from empty queue");

	// a configuration write lands in the seed register
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (init_q == $past(cfg_wdata)))
		else $error("init_value write lost");

endmodule

`default_nettype wire

### rtl/lbh_front.sv
// Front end: packs key bytes into group words, counts the key length and
// hands one job per finished group to the queue. Depends on lbh_pkg, lbh_if.
`default_nettype none

module lbh_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	lbh_byte_if.sink          key,
	output logic              push,
	input  wire logic         q_ready,
	output lbh_pkg::job_t     job
);
	import lbh_pkg::*;

	logic [31:0]            acc_a_q, acc_b_q, pend_q;
	logic [3:0]             pos_q;
	logic [LENGTH_BITS-1:0] cnt_q;
	logic                   ovf_q;
	logic                   first_q;

	logic [31:0]            wa_n, wb_n, wp_n;
	logic [LENGTH_BITS-1:0] cnt_n;
	logic                   ovf_n;
	logic                   accept;
	logic                   group_end;

	assign key.ready = q_ready;
	assign accept    = key.valid && q_ready;
	assign group_end = (pos_q == GROUP_LAST);
	assign push      = accept && (group_end || key.last_byte);

	assign cnt_n = cnt_q + LENGTH_BITS'(1);
	assign ovf_n = ovf_q || (cnt_n == '0);

	// group words start at zero, so placing a byte equals adding it
	always_comb begin
		wa_n = acc_a_q;
		wb_n = acc_b_q;
		wp_n = pend_q;
		case (pos_q[3:2])
			2'd0: wa_n[{pos_q[1:0], 3'b000} +: 8] = key.data_byte;
			2'd1: wb_n[{pos_q[1:0], 3'b000} +: 8] = key.data_byte;
			default: wp_n[{pos_q[1:0], 3'b000} +: 8] = key.data_byte;
		endcase
	end

	always_comb begin
		job.wa      = wa_n;
		job.wb      = wb_n;
		// tail bytes 8..10 sit one byte higher in c; length folded in here
		job.wc      = group_end ? wp_n : ({wp_n[23:0], 8'h00} + 32'(cnt_n));
		job.full    = group_end;
		job.closing = key.last_byte;
		job.first   = first_q;
		job.count   = cnt_n;
		job.ovf     = ovf_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_a_q <= '0;
			acc_b_q <= '0;
			pend_q  <= '0;
			pos_q   <= '0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			first_q <= 1'b1;
		end else if (accept) begin
			if (push) begin
				acc_a_q <= '0;
				acc_b_q <= '0;
				pend_q  <= '0;
				pos_q   <= '0;
				first_q <= key.last_byte;
			end else begin
				acc_a_q <= wa_n;
				acc_b_q <= wb_n;
				pend_q  <= wp_n;
				pos_q   <= pos_q + 4'd1;
			end
			if (key.last_byte) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				cnt_q <= cnt_n;
				ovf_q <= ovf_n;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/lbh_fifo.sv
// Short job queue between the front end and the mixer.
// Depends on lbh_pkg for the job type and depth.
`default_nettype none

module lbh_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire lbh_pkg::job_t  wr_job,
	output logic                ready,
	input  wire logic           pop,
	output lbh_pkg::job_t       rd_job,
	output logic                valid
);
	import lbh_pkg::*;

	job_t                 mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_BITS:0]   fill_q;

	assign ready  = (fill_q != (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign valid  = (fill_q != '0);
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			case ({push, pop})
				2'b10: fill_q <= fill_q + (QPTR_BITS+1)'(1);
				2'b01: fill_q <= fill_q - (QPTR_BITS+1)'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/lbh_back.sv
// Back end: adds each job into the three hash words and runs the lookup2 mix,
// one mix row per cycle; a closing job then drives the result register. Depends on lbh_pkg, lbh_if.
`default_nettype none

module lbh_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	input  wire lbh_pkg::job_t  q_job,
	output logic                pop,
	input  wire logic [31:0]    init_value,
	lbh_hash_if.source          hash
);
	import lbh_pkg::*;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
	} words_t;

	localparam logic [3:0] ROW_LAST = 4'd8;

	function automatic words_t mix_row(input words_t w, input logic [3:0] row);
		words_t r;
		r = w;
		case (row)
			4'd0: r.a = (w.a - w.b - w.c) ^ (w.c >> 13);
			4'd1: r.b = (w.b - w.c - w.a) ^ (w.a << 8);
			4'd2: r.c = (w.c - w.a - w.b) ^ (w.b >> 13);
			4'd3: r.a = (w.a - w.b - w.c) ^ (w.c >> 12);
			4'd4: r.b = (w.b - w.c - w.a) ^ (w.a << 16);
			4'd5: r.c = (w.c - w.a - w.b) ^ (w.b >> 5);
			4'd6: r.a = (w.a - w.b - w.c) ^ (w.c >> 3);
			4'd7: r.b = (w.b - w.c - w.a) ^ (w.a << 10);
			4'd8: r.c = (w.c - w.a - w.b) ^ (w.b >> 15);
			default: r = w;
		endcase
		return r;
	endfunction

	back_state_t state_q, state_n;
	words_t      w_q, w_base;
	job_t        job_q;
	logic [3:0]  row_q;
	logic        pass2_q;
	logic        out_valid_q;
	logic [31:0] hash_q;
	logic        too_long_q;

	logic load_en, mix_en, addlen_en, emit_en;
	logic slot_free;

	assign slot_free = !out_valid_q || hash.ready;

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) state_n = ST_MIX;
			end
			ST_MIX: begin
				if (row_q == ROW_LAST) begin
					if (job_q.full && job_q.closing && !pass2_q) state_n = ST_ADDLEN;
					else if (job_q.closing)                      state_n = ST_EMIT;
					else                                         state_n = ST_IDLE;
				end
			end
			ST_ADDLEN: state_n = ST_MIX;
			ST_EMIT: begin
				if (slot_free) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		load_en   = 1'b0;
		mix_en    = 1'b0;
		addlen_en = 1'b0;
		emit_en   = 1'b0;
		case (state_q)
			ST_IDLE:   load_en   = q_valid;
			ST_MIX:    mix_en    = 1'b1;
			ST_ADDLEN: addlen_en = 1'b1;
			ST_EMIT:   emit_en   = slot_free;
			default: ;
		endcase
	end

	assign pop = load_en;

	always_comb begin
		if (q_job.first) begin
			w_base.a = GOLDEN_WORD;
			w_base.b = GOLDEN_WORD;
			w_base.c = init_value;
		end else begin
			w_base = w_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			job_q <= q_job;
			w_q.a <= w_base.a + q_job.wa;
			w_q.b <= w_base.b + q_job.wb;
			w_q.c <= w_base.c + q_job.wc;
		end else if (mix_en) begin
			w_q <= mix_row(w_q, row_q);
		end else if (addlen_en) begin
			w_q.c <= w_q.c + 32'(job_q.count);
		end
		if (emit_en) begin
			hash_q     <= w_q.c;
			too_long_q <= job_q.ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_q       <= '0;
			pass2_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (load_en) begin
				row_q   <= '0;
				pass2_q <= 1'b0;
			end else if (mix_en) begin
				row_q <= row_q + 4'd1;
			end else if (addlen_en) begin
				row_q   <= '0;
				pass2_q <= 1'b1;
			end
			if (emit_en)         out_valid_q <= 1'b1;
			else if (hash.ready) out_valid_q <= 1'b0;
		end
	end

	assign hash.valid    = out_valid_q;
	assign hash.digest   = hash_q;
	assign hash.too_long = too_long_q;

endmodule

`default_nettype wire
